>>> rtl/fspa_pkg.sv
package fspa_pkg;

  localparam int OPCODE_W   = 2;
  localparam int REQ_W      = 31;
  localparam int IN_ADDR_W  = 32;
  localparam int STATUS_W   = 3;
  localparam int OUT_ADDR_W = 32;
  localparam int BASE_W     = 32;
  localparam int COUNT_W    = 11;
  localparam int SIZE_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int FRESH_W    = 64;

  localparam logic [BASE_W-1:0]  RST_POOL_BASE  = '0;
  localparam logic [COUNT_W-1:0] RST_SLOT_COUNT = 11'd1024;
  localparam logic [SIZE_W-1:0]  RST_SLOT_SIZE  = 17'd8;
  localparam logic [SIZE_W-1:0]  MIN_SLOT_SIZE  = 17'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SIZE  = 2'd2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESTART = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED   = 3'd0,
    ST_OVERSIZE  = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FREED     = 3'd3,
    ST_OUTSIDE   = 3'd4,
    ST_OVERFLOW  = 3'd5,
    ST_RESTARTED = 3'd6
  } status_t;

endpackage

>>> rtl/fspa_stack.sv
module fspa_stack #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/fspa_sizer.sv
module fspa_sizer #(
  parameter int ADDR_WIDTH = 32,
  parameter int CNT_W      = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ADDR_WIDTH-1:0]      base,
  input  logic [fspa_pkg::SIZE_W-1:0] size,
  input  logic [CNT_W-1:0]           limit,
  output logic                       active,
  output logic                       done,
  output logic [ADDR_WIDTH-1:0]      pool_end
);

  localparam int SW = fspa_pkg::SIZE_W;
  localparam int PW = ((ADDR_WIDTH > SW + CNT_W) ? ADDR_WIDTH : SW + CNT_W) + 1;
  localparam int BW = $clog2(CNT_W);

  logic                  active_r, active_nxt;
  logic                  done_r, done_nxt;
  logic [BW-1:0]         bit_r, bit_nxt;
  logic [CNT_W-1:0]      q_r, q_nxt;
  logic [PW-1:0]         prod_r, prod_nxt;
  logic [ADDR_WIDTH-1:0] base_r, base_nxt;
  logic [ADDR_WIDTH-1:0] span_r, span_nxt;
  logic [SW-1:0]         size_r, size_nxt;
  logic [CNT_W-1:0]      limit_r, limit_nxt;
  logic [ADDR_WIDTH-1:0] end_r, end_nxt;
  logic [CNT_W-1:0]      cand;
  logic [PW-1:0]         cand_prod;
  logic                  take;

  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    bit_nxt    = bit_r;
    q_nxt      = q_r;
    prod_nxt   = prod_r;
    base_nxt   = base_r;
    span_nxt   = span_r;
    size_nxt   = size_r;
    limit_nxt  = limit_r;
    end_nxt    = end_r;
    cand       = q_r | (CNT_W'(1) << bit_r);
    cand_prod  = prod_r + (PW'(size_r) << bit_r);
    take       = (cand <= limit_r) && (cand_prod <= PW'(span_r));
    if (start) begin
      active_nxt = 1'b1;
      bit_nxt    = BW'(CNT_W - 1);
      q_nxt      = '0;
      prod_nxt   = '0;
      base_nxt   = base;
      span_nxt   = ~base;
      size_nxt   = size;
      limit_nxt  = limit;
    end else if (active_r) begin
      if (take) begin
        q_nxt    = cand;
        prod_nxt = cand_prod;
      end
      if (bit_r == '0) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
        end_nxt    = base_r + prod_nxt[ADDR_WIDTH-1:0];
      end else begin
        bit_nxt = bit_r - BW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_r   <= bit_nxt;
    q_r     <= q_nxt;
    prod_r  <= prod_nxt;
    base_r  <= base_nxt;
    span_r  <= span_nxt;
    size_r  <= size_nxt;
    limit_r <= limit_nxt;
    end_r   <= end_nxt;
  end

  assign active   = active_r;
  assign done     = done_r;
  assign pool_end = end_r;

endmodule

>>> rtl/fixed_slot_pool_allocator_top.sv
// Fixed-slot pool allocator. A request is taken at a clock edge with start high and busy low,
// and allocate and free requests can be issued back to back, one per cycle, while no restart
// holds busy high. Each request except the unused opcode produces one result, shown for
// exactly one cycle with out_valid; the receiver cannot stall, so it must take every result
// as it appears. Allocations pop the most recently freed address first, with the stack top
// held in a forwarding register so a pop can follow a push in the next cycle. A restart sizes
// the pool with a bit-serial search, one quotient bit per cycle, and busy stays high while the
// restart waits in the input register and the search runs. Configuration writes are accepted
// at any time but must be made while no request is outstanding; base and slot size apply at
// once, while the pool end is rebuilt only by a restart or reset.
module fixed_slot_pool_allocator_top #(
  parameter int MAX_SLOTS  = 1024,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [fspa_pkg::OPCODE_W-1:0]   in_opcode,
  input  logic [fspa_pkg::REQ_W-1:0]      in_request_size,
  input  logic [fspa_pkg::IN_ADDR_W-1:0]  in_address,
  output logic                            out_valid,
  output logic [fspa_pkg::STATUS_W-1:0]   out_status,
  output logic [fspa_pkg::OUT_ADDR_W-1:0] out_slot_address,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fspa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fspa_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW    = $clog2(MAX_SLOTS + 1);
  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int FW    = fspa_pkg::FRESH_W;
  localparam int SW    = fspa_pkg::SIZE_W;
  localparam int OW    = fspa_pkg::OUT_ADDR_W;
  localparam int RW    = fspa_pkg::REQ_W;

  localparam logic [64:0] MASK_EXT = (65'd1 << ADDR_WIDTH) - 65'd1;
  localparam logic [64:0] N_RST    = (MAX_SLOTS < 1024) ? 65'(MAX_SLOTS) : 65'd1024;
  localparam logic [64:0] FIT_RST  = MASK_EXT / 65'd8;
  localparam logic [64:0] END_RST  = ((N_RST > FIT_RST) ? FIT_RST : N_RST) * 65'd8;

  logic [fspa_pkg::BASE_W-1:0]  pool_base_r;
  logic [fspa_pkg::COUNT_W-1:0] slot_count_r;
  logic [SW-1:0]                slot_size_r;

  logic                         in_vld_r;
  logic [fspa_pkg::OPCODE_W-1:0] in_op_r;
  logic [fspa_pkg::REQ_W-1:0]   in_req_r;
  logic [ADDR_WIDTH-1:0]        in_addr_r;

  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [FW-1:0]         fresh_r, fresh_nxt;
  logic [ADDR_WIDTH-1:0] pool_end_r, pool_end_nxt;
  logic                  top_sel_r, top_sel_nxt;
  logic [ADDR_WIDTH-1:0] push_val_r;

  logic                   res_vld_r, res_vld_nxt;
  fspa_pkg::status_t      res_status_r, res_status_nxt;
  logic [OW-1:0]          res_slot_r, res_slot_nxt;

  logic [SW-1:0]         eff_size;
  logic [ADDR_WIDTH-1:0] eff_base;
  logic [CW-1:0]         eff_count;
  logic [ADDR_WIDTH-1:0] top_val;
  logic [ADDR_WIDTH-1:0] rd_data;
  logic [CW-1:0]         rd_ptr;
  logic                  push_we;
  logic                  sz_start;
  logic                  sz_active;
  logic                  sz_done;
  logic [ADDR_WIDTH-1:0] sz_end;
  logic                  accept;

  assign eff_size  = (slot_size_r < fspa_pkg::MIN_SLOT_SIZE) ? fspa_pkg::MIN_SLOT_SIZE
                                                             : slot_size_r;
  assign eff_base  = ADDR_WIDTH'(pool_base_r);
  assign eff_count = (32'(slot_count_r) > 32'(MAX_SLOTS)) ? CW'(MAX_SLOTS)
                                                          : CW'(slot_count_r);
  assign top_val   = top_sel_r ? push_val_r : rd_data;

  assign busy      = (in_vld_r && (in_op_r == fspa_pkg::OP_RESTART)) || sz_active;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r  <= fspa_pkg::RST_POOL_BASE;
      slot_count_r <= fspa_pkg::RST_SLOT_COUNT;
      slot_size_r  <= fspa_pkg::RST_SLOT_SIZE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fspa_pkg::CFG_POOL_BASE: begin
          pool_base_r <= cfg_data;
        end
        fspa_pkg::CFG_SLOT_COUNT: begin
          slot_count_r <= cfg_data[fspa_pkg::COUNT_W-1:0];
        end
        fspa_pkg::CFG_SLOT_SIZE: begin
          slot_size_r <= cfg_data[SW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_op_r   <= in_opcode;
      in_req_r  <= in_request_size;
      in_addr_r <= ADDR_WIDTH'(in_address);
    end
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    fresh_nxt      = fresh_r;
    pool_end_nxt   = pool_end_r;
    top_sel_nxt    = 1'b0;
    res_vld_nxt    = 1'b0;
    res_status_nxt = fspa_pkg::ST_GRANTED;
    res_slot_nxt   = '0;
    push_we        = 1'b0;
    sz_start       = 1'b0;
    if (sz_done) begin
      cnt_nxt        = '0;
      fresh_nxt      = FW'(sz_end);
      pool_end_nxt   = sz_end;
      res_vld_nxt    = 1'b1;
      res_status_nxt = fspa_pkg::ST_RESTARTED;
    end else if (in_vld_r) begin
      unique case (in_op_r)
        fspa_pkg::OP_ALLOC: begin
          res_vld_nxt = 1'b1;
          if (in_req_r > RW'(eff_size)) begin
            res_status_nxt = fspa_pkg::ST_OVERSIZE;
          end else if (cnt_r != '0) begin
            cnt_nxt      = cnt_r - CW'(1);
            res_slot_nxt = OW'(top_val);
          end else if (fresh_r > FW'(eff_base)) begin
            fresh_nxt    = fresh_r - FW'(eff_size);
            res_slot_nxt = fresh_nxt[OW-1:0];
          end else begin
            res_status_nxt = fspa_pkg::ST_EMPTY;
          end
        end
        fspa_pkg::OP_FREE: begin
          res_vld_nxt = 1'b1;
          if ((in_addr_r >= eff_base) && (in_addr_r < pool_end_r)) begin
            if (cnt_r >= CW'(MAX_SLOTS)) begin
              res_status_nxt = fspa_pkg::ST_OVERFLOW;
            end else begin
              push_we        = 1'b1;
              top_sel_nxt    = 1'b1;
              cnt_nxt        = cnt_r + CW'(1);
              res_status_nxt = fspa_pkg::ST_FREED;
            end
          end else begin
            res_status_nxt = fspa_pkg::ST_OUTSIDE;
          end
        end
        fspa_pkg::OP_RESTART: begin
          sz_start = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign rd_ptr = cnt_nxt - CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      fresh_r    <= END_RST[FW-1:0];
      pool_end_r <= END_RST[ADDR_WIDTH-1:0];
      top_sel_r  <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      fresh_r    <= fresh_nxt;
      pool_end_r <= pool_end_nxt;
      top_sel_r  <= top_sel_nxt;
      res_vld_r  <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_we) begin
      push_val_r <= in_addr_r;
    end
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
  end

  fspa_stack #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (ADDR_WIDTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (push_we),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data (in_addr_r),
    .rd_addr (rd_ptr[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  fspa_sizer #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .CNT_W      (CW)
  ) u_sizer (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sz_start),
    .base     (eff_base),
    .size     (eff_size),
    .limit    (eff_count),
    .active   (sz_active),
    .done     (sz_done),
    .pool_end (sz_end)
  );

  assign out_valid        = res_vld_r;
  assign out_status       = res_status_r;
  assign out_slot_address = res_slot_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_SLOTS))
    else $error("free stack count exceeds its depth");

  a_no_work_while_sizing: assert property (@(posedge clk) disable iff (!rst_n)
    sz_active |-> !in_vld_r)
    else $error("request in flight while the pool is being sized");

  a_zero_slot_unless_granted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != fspa_pkg::ST_GRANTED)) |-> (out_slot_address == '0))
    else $error("slot address set on a result that is not a grant");

  a_alloc_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && ((in_opcode == fspa_pkg::OP_ALLOC) || (in_opcode == fspa_pkg::OP_FREE)))
      |=> ##1 out_valid)
    else $error("allocate or free request did not produce a result in two cycles");

endmodule

>>> tb/pool_alloc_checker.sv
module pool_alloc_checker
  import fspa_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic [OPCODE_W-1:0]     in_opcode,
  input  logic [REQ_W-1:0]        in_request_size,
  input  logic [IN_ADDR_W-1:0]    in_address,
  input  logic                    out_valid,
  input  logic [STATUS_W-1:0]     out_status,
  input  logic [OUT_ADDR_W-1:0]   out_slot_address,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output int                      failures,
  output int                      outstanding
);

  localparam int          STACK_DEPTH = 1024;
  localparam logic [63:0] ADDR_MASK   = 64'hFFFF_FFFF;

  typedef struct packed {
    status_t                 status;
    logic [OUT_ADDR_W-1:0]   slot;
  } pool_result_t;

  pool_result_t       results_due[$];
  logic [31:0]        returned_addr [STACK_DEPTH];
  int unsigned        returned_cnt;
  logic [63:0]        fresh_ptr;
  logic [63:0]        pool_limit;
  logic [BASE_W-1:0]  base_reg;
  logic [COUNT_W-1:0] count_reg;
  logic [SIZE_W-1:0]  size_reg;

  function automatic logic [63:0] slot_bytes();
    return (size_reg < MIN_SLOT_SIZE) ? 64'(MIN_SLOT_SIZE) : 64'(size_reg);
  endfunction

  function automatic void rebuild_pool();
    logic [63:0] slots;
    logic [63:0] fit;
    slots = (count_reg > STACK_DEPTH) ? 64'(STACK_DEPTH) : 64'(count_reg);
    fit = (ADDR_MASK - 64'(base_reg)) / slot_bytes();
    if (slots > fit) slots = fit;
    pool_limit = 64'(base_reg) + slots * slot_bytes();
    fresh_ptr = pool_limit;
    returned_cnt = 0;
  endfunction

  // Returned slots are handed out before the fresh pointer walks further down.
  function automatic status_t grant_slot(logic [REQ_W-1:0] req, output logic [31:0] slot);
    slot = '0;
    if (64'(req) > slot_bytes()) return ST_OVERSIZE;
    if (returned_cnt > 0) begin
      returned_cnt--;
      slot = returned_addr[returned_cnt];
      return ST_GRANTED;
    end
    if (fresh_ptr > 64'(base_reg)) begin
      fresh_ptr = fresh_ptr - slot_bytes();
      slot = fresh_ptr[31:0];
      return ST_GRANTED;
    end
    return ST_EMPTY;
  endfunction

  function automatic status_t release_slot(logic [IN_ADDR_W-1:0] addr);
    if (64'(addr) < 64'(base_reg) || 64'(addr) >= pool_limit) return ST_OUTSIDE;
    if (returned_cnt >= STACK_DEPTH) return ST_OVERFLOW;
    returned_addr[returned_cnt] = addr;
    returned_cnt++;
    return ST_FREED;
  endfunction

  always @(posedge clk) begin
    pool_result_t due;
    logic [31:0]  granted;
    if (!rst_n) begin
      base_reg = RST_POOL_BASE;
      count_reg = RST_SLOT_COUNT;
      size_reg = RST_SLOT_SIZE;
      rebuild_pool();
      results_due.delete();
    end else begin
      if (out_valid) begin
        if (results_due.size() == 0) begin
          failures++;
          $display("%0t: unexpected result, expected none, got status %0d slot %h",
                   $time, out_status, out_slot_address);
        end else begin
          due = results_due.pop_front();
          if (out_status !== due.status) begin
            failures++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, due.status, out_status);
          end
          if (out_slot_address !== due.slot) begin
            failures++;
            $display("%0t: slot address mismatch, expected %h, got %h",
                     $time, due.slot, out_slot_address);
          end
        end
      end
      if (start && !busy) begin
        due.slot = '0;
        case (in_opcode)
          OP_ALLOC: begin
            due.status = grant_slot(in_request_size, granted);
            due.slot = granted;
            results_due.push_back(due);
          end
          OP_FREE: begin
            due.status = release_slot(in_address);
            results_due.push_back(due);
          end
          OP_RESTART: begin
            rebuild_pool();
            due.status = ST_RESTARTED;
            results_due.push_back(due);
          end
          default: ;
        endcase
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POOL_BASE:  base_reg = cfg_data;
          CFG_SLOT_COUNT: count_reg = cfg_data[COUNT_W-1:0];
          CFG_SLOT_SIZE:  size_reg = cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding = results_due.size();
  end

endmodule

>>> tb/tb.sv
module tb;
  import fspa_pkg::*;

  localparam logic [OPCODE_W-1:0]  OP_UNUSED     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;
  localparam int                   SETTLE_CYCLES = 20;
  localparam int                   ROUNDS        = 10;
  localparam int                   ROUND_ITEMS   = 78;
  localparam int                   FLOOD_FREES   = 1030;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [OPCODE_W-1:0]   in_opcode;
  logic [REQ_W-1:0]      in_request_size;
  logic [IN_ADDR_W-1:0]  in_address;
  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [OUT_ADDR_W-1:0] out_slot_address;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    failures;
  int                    outstanding;

  bit                    bursty;
  logic [BASE_W-1:0]     cur_base;
  logic [COUNT_W-1:0]    cur_count;
  logic [SIZE_W-1:0]     cur_size;

  fixed_slot_pool_allocator_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_request_size(in_request_size), .in_address(in_address),
    .out_valid(out_valid), .out_status(out_status), .out_slot_address(out_slot_address),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pool_alloc_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_request_size(in_request_size), .in_address(in_address),
    .out_valid(out_valid), .out_status(out_status), .out_slot_address(out_slot_address),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned eff_size();
    return (cur_size < MIN_SLOT_SIZE) ? 8 : int'(cur_size);
  endfunction

  function automatic int unsigned eff_count();
    if (cur_count == 0) return 1;
    return (cur_count > 1024) ? 1024 : int'(cur_count);
  endfunction

  function automatic logic [IN_ADDR_W-1:0] pick_address();
    logic [31:0] slot_off;
    slot_off = $urandom_range(0, eff_count() - 1) * eff_size();
    case ($urandom_range(0, 9))
      0: return cur_base - 32'd1;
      1: return cur_base + eff_count() * eff_size();
      2: return $urandom();
      3: return cur_base + slot_off + $urandom_range(1, eff_size() - 1);
      default: return cur_base + slot_off;
    endcase
  endfunction

  function automatic logic [REQ_W-1:0] pick_request_size();
    case ($urandom_range(0, 7))
      0: return REQ_W'($urandom());
      1: return REQ_W'(eff_size() + 1);
      2: return REQ_W'(eff_size());
      3: return '0;
      default: return REQ_W'($urandom_range(0, eff_size()));
    endcase
  endfunction

  task automatic send(logic [OPCODE_W-1:0] op, logic [REQ_W-1:0] req,
                      logic [IN_ADDR_W-1:0] addr);
    if (bursty && $urandom_range(0, 3) == 0) begin
      if (start) start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_request_size <= req;
    in_address <= addr;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic send_random();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 48) send(OP_ALLOC, pick_request_size(), $urandom());
    else if (pick < 88) send(OP_FREE, REQ_W'($urandom()), pick_address());
    else if (pick < 95) send(OP_RESTART, REQ_W'($urandom()), $urandom());
    else send(OP_UNUSED, REQ_W'($urandom()), $urandom());
  endtask

  task automatic drain();
    if (start) start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic configure(logic [31:0] base, logic [31:0] count, logic [31:0] size,
                           bit spare);
    write_reg(CFG_POOL_BASE, base);
    write_reg(CFG_SLOT_COUNT, count);
    write_reg(CFG_SLOT_SIZE, size);
    if (spare) write_reg(CFG_SPARE, $urandom());
    cfg_valid <= 1'b0;
    cur_base = base;
    cur_count = count[COUNT_W-1:0];
    cur_size = size[SIZE_W-1:0];
  endtask

  initial begin
    logic [31:0] base;
    logic [31:0] count;
    logic [31:0] size;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_ALLOC;
    in_request_size = '0;
    in_address = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_POOL_BASE;
    cfg_data = '0;
    bursty = 1'b0;
    cur_base = RST_POOL_BASE;
    cur_count = RST_SLOT_COUNT;
    cur_size = RST_SLOT_SIZE;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset pool: LIFO reuse, boundaries, unaligned free and the unused opcode.
    send(OP_ALLOC, '0, $urandom());
    send(OP_ALLOC, 31'd8, '1);
    send(OP_ALLOC, 31'd9, '0);
    send(OP_ALLOC, '1, $urandom());
    send(OP_FREE, REQ_W'($urandom()), 32'd8184);
    send(OP_FREE, REQ_W'($urandom()), 32'd3);
    send(OP_FREE, REQ_W'($urandom()), 32'd8192);
    send(OP_FREE, REQ_W'($urandom()), '1);
    send(OP_FREE, REQ_W'($urandom()), '0);
    repeat (3) send(OP_ALLOC, 31'd1, $urandom());
    send(OP_UNUSED, '1, '1);
    send(OP_RESTART, '1, '1);
    drain();

    // The pool near the top of the address space is cut short.
    configure(32'hFFFF_F000, 32'hFFFF_F400, 32'd5, 1'b1);
    send(OP_RESTART, '0, '0);
    send(OP_ALLOC, 31'd8, $urandom());
    send(OP_FREE, REQ_W'($urandom()), '1);
    send(OP_FREE, REQ_W'($urandom()), 32'hFFFF_FFF0);
    drain();

    configure(32'd0, 32'd0, 32'd131071, 1'b0);
    send(OP_RESTART, '0, '0);
    send(OP_ALLOC, 31'd0, $urandom());
    drain();

    configure(32'd0, 32'd1, 32'd65536, 1'b0);
    send(OP_RESTART, '0, '0);
    send(OP_ALLOC, 31'd65537, $urandom());
    send(OP_ALLOC, 31'd65536, $urandom());
    send(OP_ALLOC, 31'd0, $urandom());
    drain();

    // Repeated frees of a tiny pool fill the return stack until pushes are dropped.
    bursty = 1'b1;
    configure($urandom() & 32'hFFFF_FFF8, 32'd4, 32'd8, 1'b0);
    send(OP_RESTART, REQ_W'($urandom()), $urandom());
    repeat (FLOOD_FREES) send(OP_FREE, REQ_W'($urandom()), cur_base + 8 * $urandom_range(0, 3));
    repeat (12) send(OP_ALLOC, REQ_W'($urandom_range(0, 8)), $urandom());
    drain();

    for (int r = 0; r < ROUNDS; r++) begin
      bursty = (r < ROUNDS - 1) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 4))
        0: base = 32'd0;
        1: base = 32'hFFFF_FFFF;
        2: base = $urandom();
        3: base = 32'hFFFF_FFFF - $urandom_range(0, 1 << 20);
        default: base = $urandom() & 32'h00FF_FFF8;
      endcase
      case ($urandom_range(0, 5))
        0: count = 32'd0;
        1: count = 32'd1;
        2: count = 32'd1024;
        3: count = 32'd2047;
        default: count = $urandom_range(2, 48);
      endcase
      case ($urandom_range(0, 4))
        0: size = $urandom_range(0, 7);
        1: size = 32'd65536;
        2: size = 32'd131071;
        3: size = $urandom_range(8, 300);
        default: size = 8 * $urandom_range(1, 16);
      endcase
      if ($urandom_range(0, 1) == 0) count = count | (($urandom() >> 11) << 11);
      if ($urandom_range(0, 1) == 0) size = size | (($urandom() >> 17) << 17);
      configure(base, count, size, $urandom_range(0, 3) == 0);
      if (r == 0 || $urandom_range(0, 2) != 0) send(OP_RESTART, REQ_W'($urandom()), $urandom());
      repeat (ROUND_ITEMS) send_random();
      drain();
    end

    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/fspa_pkg.sv
rtl/fspa_stack.sv
rtl/fspa_sizer.sv
rtl/fixed_slot_pool_allocator_top.sv
tb/pool_alloc_checker.sv
tb/tb.sv
